// File: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes of the sorted priority queue
// Action and status codes, the stored entry layout and the control word
// that the top level broadcasts to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

	typedef logic [1:0] action_t;
	typedef logic [1:0] status_t;

	localparam action_t ACT_INSERT = 2'd0;
	localparam action_t ACT_REMOVE = 2'd1;
	localparam action_t ACT_CLEAR  = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0] role;
		logic [3:0] level;
	} entry_t;

	typedef struct packed {
		logic   insert;
		logic   remove;
		entry_t item;
	} cell_ctrl_t;

endpackage

// File: src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry and flags whether it sorts below the item being inserted.
// On insert it keeps, takes the new item or takes its upper neighbor; on
// remove it takes its lower neighbor.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occupied,
	input  logic       prev_lt,
	input  entry_t     prev_entry,
	input  entry_t     next_entry,
	output logic       lt,
	output entry_t     entry
);

	entry_t entry_q;

	// The queue is sorted, so these flags rise once along the row and stay high.
	assign lt    = !occupied || (entry_q.level < ctrl.item.level);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (lt && !prev_lt) begin
				entry_q <= ctrl.item;
			end else if (lt) begin
				entry_q <= prev_entry;
			end
		end else if (ctrl.remove) begin
			entry_q <= next_entry;
		end
	end

endmodule

// File: src/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue in a row of cells
// Usage: drive action, role and level with start high; a beat is taken at a
// clock edge where start is high and busy is low. Busy stays low, so one
// action is taken every cycle. Insert places the item ahead of the first
// entry with a strictly lower level, remove pops the head, clear empties
// the queue. Each action gives exactly one result beat in the next cycle:
// done is high for that one cycle with status, the popped entry (zero when
// nothing is popped) and the occupancy after the action. The receiver
// cannot stall, so results must be taken as they appear.
// Throughput is one action per cycle: every cell compares its entry with
// the new level in parallel and shifts with its neighbor in the same edge.
// Reset empties the queue and clears done; entry contents are not reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] action,
	input  logic [1:0] role,
	input  logic [3:0] level,
	output logic       done,
	output logic [1:0] status,
	output logic [1:0] out_role,
	output logic [3:0] out_level,
	output logic [4:0] occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic          take;
	logic          full;
	logic          empty;
	cell_ctrl_t    ctrl;
	status_t       status_next;
	entry_t        pop_next;
	logic [CAPACITY-1:0] lt_vec;
	entry_t        entries [CAPACITY];

	logic          done_q;
	status_t       status_q;
	entry_t        pop_q;
	logic [4:0]    occupancy_q;

	assign busy  = 1'b0;
	assign take  = start && !busy;
	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);

	always_comb begin
		ctrl.insert = 1'b0;
		ctrl.remove = 1'b0;
		ctrl.item.role  = role;
		ctrl.item.level = level;
		status_next = ST_OK;
		pop_next    = '0;
		count_next  = count_q;
		case (action)
			ACT_INSERT: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					ctrl.insert = take;
					count_next  = count_q + CW'(1);
				end
			end
			ACT_REMOVE: begin
				if (empty) begin
					status_next = ST_EMPTY;
				end else begin
					ctrl.remove = take;
					pop_next    = entries[0];
					count_next  = count_q - CW'(1);
				end
			end
			ACT_CLEAR: count_next = '0;
			default: count_next = count_q;
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   occ;
		logic   prev_lt;
		entry_t prev_entry;
		entry_t next_entry;

		assign occ = (count_q > CW'(i));

		if (i == 0) begin : g_head
			assign prev_lt    = 1'b0;
			assign prev_entry = ctrl.item;
		end else begin : g_body
			assign prev_lt    = lt_vec[i-1];
			assign prev_entry = entries[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_entry = entries[i];
		end else begin : g_inner
			assign next_entry = entries[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (occ),
			.prev_lt    (prev_lt),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.lt         (lt_vec[i]),
			.entry      (entries[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= take;
			if (take) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q    <= status_next;
			pop_q       <= pop_next;
			occupancy_q <= 5'(count_next);
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign out_role  = pop_q.role;
	assign out_level = pop_q.level;
	assign occupancy = occupancy_q;

endmodule

// File: src/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker: port-level checks of the sorted priority queue
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
	import spq_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] action,
	input logic       done,
	input logic [1:0] status,
	input logic [1:0] out_role,
	input logic [3:0] out_level,
	input logic [4:0] occupancy
);

	// Every taken beat gives exactly one result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy))
		else $error("result strobe does not follow a taken beat");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_CLEAR) |=> (done && occupancy == 5'd0))
		else $error("clear did not empty the queue");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (occupancy == 5'd0))
		else $error("empty status with entries stored");

	a_no_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (out_role == 2'd0 && out_level == 4'd0))
		else $error("failed action returned a popped entry");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
